/* rtl/edd_pkg.sv */
package edd_pkg;

  localparam int EDD_MAX_WIDTH = 1024;
  localparam int EDD_CHANNELS  = 4;
  localparam int EDD_CH_W      = 8;
  localparam int EDD_ERR_W     = 9;
  localparam int EDD_ERRWORD_W = EDD_CHANNELS * EDD_ERR_W;

  localparam int EDD_IMAGE_WIDTH_W  = 11;
  localparam int EDD_IMAGE_HEIGHT_W = 16;
  localparam int EDD_SHIFT_W        = 3;

  localparam int EDD_PADDR_W = 4;
  localparam int EDD_PDATA_W = 32;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_ERROR_SHIFT  = 2'd2
  } edd_reg_t;

  localparam logic [EDD_IMAGE_WIDTH_W-1:0]  EDD_WIDTH_RESET  = 11'd1024;
  localparam logic [EDD_IMAGE_HEIGHT_W-1:0] EDD_HEIGHT_RESET = 16'd480;
  localparam logic [EDD_SHIFT_W-1:0]        EDD_SHIFT_RESET  = 3'd5;

  // Diffusion weights by neighbor.
  localparam logic [2:0] EDD_W_RIGHT      = 3'd7;
  localparam logic [2:0] EDD_W_DOWN_LEFT  = 3'd3;
  localparam logic [2:0] EDD_W_DOWN       = 3'd5;
  localparam logic [2:0] EDD_W_DOWN_RIGHT = 3'd1;

  localparam logic [EDD_CH_W-1:0] EDD_FULL = 8'hFF;

  // Adds a weighted, floor-shifted error to a channel and clamps to 0..255.
  function automatic logic [7:0] add_clamped(logic [7:0] v, logic signed [8:0] e,
                                             logic [2:0] wgt, logic [2:0] sh);
    logic signed [12:0] prod;
    logic signed [13:0] t;
    logic [7:0]         res;
    prod = $signed({{4{e[8]}}, e}) * $signed({10'd0, wgt});
    prod = prod >>> sh;
    t    = $signed({6'd0, v}) + $signed({prod[12], prod});
    if (t < 0) begin
      res = 8'd0;
    end else if (t > 14'sd255) begin
      res = 8'd255;
    end else begin
      res = t[7:0];
    end
    return res;
  endfunction

endpackage

/* rtl/edd_ram.sv */
module edd_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read at the address being written returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/error_diffusion_dither_16color_top.sv */
// Error-diffusion dither of four-channel 8-bit pixels to 16 colors.
// Pixels enter on the s_ channel in raster order, one per request; the
// dithered pixel leaves on the m_ channel with tlast on the last pixel of
// each row and tuser on the last pixel of the frame. The user must set
// geometry and the error shift over the APB port only while idle; the
// block does not enforce it. Throughput is one pixel per clock when
// nothing stalls, set by the loop that carries each pixel's error into
// its right neighbor. The error line memory is read once per pixel for
// the up-right neighbor; at a width of three a row start waits for the
// previous row's write. Stages: A (line read), B (above-row corrections),
// final stage into the output register. Reset clears the counters, the
// error window, the right carry and all valid flags; the line memory
// needs no clearing, because the first row ignores it. A stall on
// m_tready holds the output register; the two earlier stages keep
// filling, and s_tready falls once all are full.
module error_diffusion_dither_16color_top
  import edd_pkg::*;
#(
  parameter int MAX_WIDTH = EDD_MAX_WIDTH,
  localparam int XW   = $clog2(MAX_WIDTH),
  localparam int WCMP = (XW + 1 > EDD_IMAGE_WIDTH_W) ? XW + 1 : EDD_IMAGE_WIDTH_W
) (
  input  logic                   clk,
  input  logic                   rst,
  // APB configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [EDD_PADDR_W-1:0] paddr,
  input  logic [EDD_PDATA_W-1:0] pwdata,
  output logic [EDD_PDATA_W-1:0] prdata,
  output logic                   pready,
  // Input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [31:0]            s_tdata,   // [31:0] pixel_in
  // Output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [31:0]            m_tdata,   // [31:0] pixel_out
  output logic                   m_tlast,   // row_end
  output logic                   m_tuser    // [0] frame_end
);

  typedef struct packed {
    logic [31:0]   pix;
    logic [XW-1:0] x;
    logic          x0;
    logic          rdv;
    logic          diffuse;
    logic          last_col;
    logic          frame_end;
  } a_stage_t;

  typedef struct packed {
    logic [31:0]   v;
    logic [XW-1:0] x;
    logic          x0;
    logic          diffuse;
    logic          last_col;
    logic          frame_end;
  } b_stage_t;

  // Configuration registers.
  logic [EDD_IMAGE_WIDTH_W-1:0]  image_width;
  logic [EDD_IMAGE_HEIGHT_W-1:0] image_height;
  logic [EDD_SHIFT_W-1:0]        error_shift;

  logic     cfg_wr;
  edd_reg_t cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = edd_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= EDD_WIDTH_RESET;
      image_height <= EDD_HEIGHT_RESET;
      error_shift  <= EDD_SHIFT_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[EDD_IMAGE_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[EDD_IMAGE_HEIGHT_W-1:0];
        REG_ERROR_SHIFT:  error_shift  <= pwdata[EDD_SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_IMAGE_WIDTH:  prdata = EDD_PDATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = EDD_PDATA_W'(image_height);
      REG_ERROR_SHIFT:  prdata = EDD_PDATA_W'(error_shift);
      default:          prdata = '0;
    endcase
  end

  // Effective geometry.
  logic [WCMP-1:0]               w_ext;
  logic [WCMP-1:0]               weff;
  logic [EDD_IMAGE_HEIGHT_W-1:0] heff;

  always_comb begin
    w_ext = WCMP'(image_width);
    if (w_ext < WCMP'(3)) begin
      weff = WCMP'(3);
    end else if (w_ext > WCMP'(MAX_WIDTH)) begin
      weff = WCMP'(MAX_WIDTH);
    end else begin
      weff = w_ext;
    end
    heff = (image_height < 16'd2) ? 16'd2 : image_height;
  end

  // Position counters, advanced on every accepted request.
  logic [XW-1:0]                 column_count;
  logic [EDD_IMAGE_HEIGHT_W-1:0] row_count;
  logic [XW:0]                   rd_addr;
  logic [XW-1:0]                 raddr;
  logic                          in_last_col;
  logic                          in_last_row;
  logic                          in_rdv;
  logic [EDD_IMAGE_HEIGHT_W:0]   row_inc;

  assign rd_addr     = {1'b0, column_count} + (XW+1)'(1);
  assign raddr       = rd_addr[XW-1:0];
  assign row_inc     = {1'b0, row_count} + 17'd1;
  assign in_last_col = WCMP'(rd_addr) >= weff;
  assign in_last_row = row_inc >= {1'b0, heff};
  assign in_rdv      = (row_count != '0) && !in_last_col;

  // Pipeline control.
  logic     a_valid, b_valid;
  a_stage_t a_q;
  b_stage_t b_q;
  logic     o_free, b_adv, b_free, a_adv, a_free, hazard, accept;

  assign o_free = !m_tvalid || m_tready;
  assign b_adv  = b_valid && o_free;
  assign b_free = !b_valid || b_adv;
  assign a_adv  = a_valid && b_free;
  assign a_free = !a_valid || a_adv;
  // A pixel still in flight may not have written the line entry this read needs.
  assign hazard = in_rdv && ((a_valid && a_q.x == raddr) || (b_valid && b_q.x == raddr));
  assign s_tready = a_free && !hazard;
  assign accept   = s_tvalid && s_tready;

  // Error line memory.
  logic                     ram_we;
  logic [EDD_ERRWORD_W-1:0] ram_wdata;
  logic [EDD_ERRWORD_W-1:0] ram_rdata;

  edd_ram #(
    .WIDTH(EDD_ERRWORD_W),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk  (clk),
    .we   (ram_we),
    .waddr(b_q.x),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (in_last_col) begin
        column_count <= '0;
        row_count    <= in_last_row ? '0 : row_inc[EDD_IMAGE_HEIGHT_W-1:0];
      end else begin
        column_count <= rd_addr[XW-1:0];
      end
    end
  end

  // Stage A: holds the pixel while the line word is read.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_q.pix       <= s_tdata;
      a_q.x         <= column_count;
      a_q.x0        <= (column_count == '0);
      a_q.rdv       <= in_rdv;
      a_q.diffuse   <= (column_count != '0) && !in_last_col && !in_last_row;
      a_q.last_col  <= in_last_col;
      a_q.frame_end <= in_last_col && in_last_row;
    end
  end

  // Window of row-above errors: up-left, up, up-right. Column zero always
  // stores a zero error, so a new row starts its window with zeros.
  logic [EDD_ERRWORD_W-1:0] win0, win1;
  logic [EDD_ERRWORD_W-1:0] w0_eff, w1_eff, w2_eff;
  logic [31:0]              above_v;

  assign w0_eff = a_q.x0 ? '0 : win0;
  assign w1_eff = a_q.x0 ? '0 : win1;
  assign w2_eff = a_q.rdv ? ram_rdata : '0;

  always_comb begin
    logic [7:0] v;
    for (int c = 0; c < EDD_CHANNELS; c++) begin
      v = a_q.pix[EDD_CH_W*c +: EDD_CH_W];
      v = add_clamped(v, $signed(w0_eff[EDD_ERR_W*c +: EDD_ERR_W]), EDD_W_DOWN_RIGHT,
                      error_shift);
      v = add_clamped(v, $signed(w1_eff[EDD_ERR_W*c +: EDD_ERR_W]), EDD_W_DOWN,
                      error_shift);
      v = add_clamped(v, $signed(w2_eff[EDD_ERR_W*c +: EDD_ERR_W]), EDD_W_DOWN_LEFT,
                      error_shift);
      above_v[EDD_CH_W*c +: EDD_CH_W] = v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win0 <= '0;
      win1 <= '0;
    end else if (a_adv) begin
      win0 <= w1_eff;
      win1 <= w2_eff;
    end
  end

  // Stage B: corrections from the row above are done.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_adv) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_q.v         <= above_v;
      b_q.x         <= a_q.x;
      b_q.x0        <= a_q.x0;
      b_q.diffuse   <= a_q.diffuse;
      b_q.last_col  <= a_q.last_col;
      b_q.frame_end <= a_q.frame_end;
    end
  end

  // Final stage: left-neighbor correction, quantization, new error.
  logic [EDD_ERRWORD_W-1:0] right_carry_error;
  logic [EDD_ERRWORD_W-1:0] carry_eff;
  logic [EDD_ERRWORD_W-1:0] errs;
  logic [31:0]              quant;

  assign carry_eff = b_q.x0 ? '0 : right_carry_error;

  always_comb begin
    logic [7:0]        v;
    logic [7:0]        q;
    logic signed [8:0] e;
    for (int c = 0; c < EDD_CHANNELS; c++) begin
      v = add_clamped(b_q.v[EDD_CH_W*c +: EDD_CH_W],
                      $signed(carry_eff[EDD_ERR_W*c +: EDD_ERR_W]), EDD_W_RIGHT,
                      error_shift);
      q = v[7] ? EDD_FULL : '0;
      e = $signed({1'b0, v}) - $signed({1'b0, q});
      quant[EDD_CH_W*c +: EDD_CH_W] = q;
      errs[EDD_ERR_W*c +: EDD_ERR_W] = b_q.diffuse ? e : '0;
    end
  end

  assign ram_we    = b_adv;
  assign ram_wdata = errs;

  always_ff @(posedge clk) begin
    if (rst) begin
      right_carry_error <= '0;
    end else if (b_adv) begin
      right_carry_error <= errs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (b_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      m_tdata <= quant;
      m_tlast <= b_q.last_col;
      m_tuser <= b_q.frame_end;
    end
  end

  // A line read that an accepted pixel uses never meets the write of the same entry.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (accept && in_rdv && ram_we) |-> (b_q.x != raddr))
    else $error("line memory read and write hit the same entry");

  // The frame end always closes a row.
  a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("frame end without row end");

  // A pixel leaves stage B only into a free output register.
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && !b_adv) |=> ($stable(m_tdata) && m_tvalid))
    else $error("pending output was overwritten");

endmodule
